// ----- src/egli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package egli_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] REG_HEIGHT_THRESHOLD    = 8'd0;
  localparam logic [7:0] REG_BASE_LOSS_BOTH_HIGH = 8'd1;
  localparam logic [7:0] REG_BASE_LOSS_ONE_HIGH  = 8'd2;
  localparam logic [7:0] REG_BASE_LOSS_BOTH_LOW  = 8'd3;

  // Register reset values.
  localparam logic [15:0] HEIGHT_THRESHOLD_RST    = 16'd160;
  localparam logic [13:0] BASE_LOSS_BOTH_HIGH_RST = 14'd5498;
  localparam logic [13:0] BASE_LOSS_ONE_HIGH_RST  = 14'd4883;
  localparam logic [13:0] BASE_LOSS_BOTH_LOW_RST  = 14'd4269;

  // Widths of the internal words.
  localparam int LogW  = 20;  // Q16 log2 of a 16-bit operand
  localparam int SumW  = 26;  // signed weighted log2 sum
  localparam int ProdW = 48;  // sum times dB scale

  // 10*log10(2) with 20 fraction bits, and the rounding constant.
  localparam logic signed [22:0]      DB_SCALE = 23'sd3156528;
  localparam logic signed [ProdW-1:0] RND_HALF = 48'sd536870912;

  // Position of the leading one of a 16-bit word (zero for a zero word).
  function automatic logic [3:0] lead_one(input logic [15:0] x);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  // log2(1 + idx/2^tb) in Q16, built by repeated squaring of a Q30
  // mantissa; every fraction bit is truncated. Used for constant tables.
  function automatic logic [15:0] mant_rom(input int tb, input int idx);
    logic [63:0] m;
    logic [15:0] r;
    m = (64'(1 << tb) + 64'(idx)) << (30 - tb);
    r = 16'd0;
    for (int k = 1; k <= 16; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h0000_0000_8000_0000) begin
        m = m >> 1;
        r[16-k] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/egli_path_loss_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_stall_o   freq, tx height, rx height, distance
// out       output     out_valid_o / out_stall_i loss_db, status
// cfg       input      cfg_valid_i / cfg_ready_o register index, write data
//
// Five register stages: leading-one detect, mantissa table, weighted sum,
// dB scale multiply, round/add base/saturate. One word enters per cycle
// while the output does not stall. The single multiplier in stage four
// sets the cycle time. Reset clears the valid bits and loads the register
// defaults. A stall at the output holds each full stage; bubbles still close
// up, so the input stalls only when every stage holds a word.
module egli_path_loss_unit
  import egli_pkg::*;
#(
  parameter int LOG_TABLE_BITS = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [15:0]        freq_mhz_i,
  input  wire logic [15:0]        tx_height_i,
  input  wire logic [15:0]        rx_height_i,
  input  wire logic [15:0]        distance_km_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      loss_db_o,
  output logic [1:0]              status_o,
  // Configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  localparam int TB       = LOG_TABLE_BITS;
  localparam int RomDepth = 2 ** TB;
  localparam int NumOps   = 4;

  // Operand slots.
  localparam int OpFreq = 0;
  localparam int OpTx   = 1;
  localparam int OpRx   = 2;
  localparam int OpDist = 3;

  // Configuration registers.
  logic [15:0] thr_q;
  logic [13:0] base_hh_q, base_h_q, base_ll_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= HEIGHT_THRESHOLD_RST;
      base_hh_q <= BASE_LOSS_BOTH_HIGH_RST;
      base_h_q  <= BASE_LOSS_ONE_HIGH_RST;
      base_ll_q <= BASE_LOSS_BOTH_LOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HEIGHT_THRESHOLD:    thr_q     <= cfg_data_i;
        REG_BASE_LOSS_BOTH_HIGH: base_hh_q <= cfg_data_i[13:0];
        REG_BASE_LOSS_ONE_HIGH:  base_h_q  <= cfg_data_i[13:0];
        REG_BASE_LOSS_BOTH_LOW:  base_ll_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Mantissa table, a constant built at elaboration.
  logic [15:0] rom [RomDepth];

  for (genvar g = 0; g < RomDepth; g++) begin : g_rom
    assign rom[g] = mant_rom(TB, g);
  end

  // Stage valid bits and enables; a stage moves when it is empty or the
  // next one moves.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // Stage 1: leading-one position and normalised mantissa bits.
  logic [15:0]   op [NumOps];
  logic [3:0]    pos_d [NumOps];
  logic [TB-1:0] man_d [NumOps];
  logic [15:0]   norm [NumOps];
  logic [3:0]    pos_q [NumOps];
  logic [TB-1:0] man_q [NumOps];
  logic          hi_tx_q, hi_rx_q, zero1_q;

  assign op[OpFreq] = freq_mhz_i;
  assign op[OpTx]   = tx_height_i;
  assign op[OpRx]   = rx_height_i;
  assign op[OpDist] = distance_km_i;

  for (genvar g = 0; g < NumOps; g++) begin : g_lod
    assign pos_d[g] = lead_one(op[g]);
    assign norm[g]  = op[g] << (4'd15 - pos_d[g]);
    assign man_d[g] = norm[g][14 -: TB];
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      pos_q   <= pos_d;
      man_q   <= man_d;
      hi_tx_q <= tx_height_i > thr_q;
      hi_rx_q <= rx_height_i > thr_q;
      zero1_q <= (freq_mhz_i == 16'd0) || (tx_height_i == 16'd0) ||
                 (rx_height_i == 16'd0) || (distance_km_i == 16'd0);
    end
  end

  // Stage 2: table look-up gives each log2 in Q16.
  logic [LogW-1:0] lg_q [NumOps];
  logic            hi_tx2_q, hi_rx2_q, zero2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      for (int i = 0; i < NumOps; i++) begin
        lg_q[i] <= {pos_q[i], rom[man_q[i]]};
      end
      hi_tx2_q <= hi_tx_q;
      hi_rx2_q <= hi_rx_q;
      zero2_q  <= zero1_q;
    end
  end

  // Stage 3: weighted log2 sum with the fraction offsets removed, and the
  // base loss picked by how many antennas are high.
  logic signed [SumW-1:0] ls [NumOps];
  logic signed [SumW-1:0] tx_term, rx_term, off, sum_d;
  logic signed [SumW-1:0] sum_q;
  logic [13:0]            base_d, base3_q;
  logic                   zero3_q;

  for (genvar g = 0; g < NumOps; g++) begin : g_ext
    assign ls[g] = $signed({{(SumW-LogW){1'b0}}, lg_q[g]});
  end

  always_comb begin
    tx_term = hi_tx2_q ? (ls[OpTx] <<< 1) : ls[OpTx];
    rx_term = hi_rx2_q ? (ls[OpRx] <<< 1) : ls[OpRx];
    off     = (26'sd24 - (hi_tx2_q ? 26'sd4 : 26'sd0)
                       - (hi_rx2_q ? 26'sd4 : 26'sd0)) <<< 16;
    sum_d   = (ls[OpDist] <<< 2) + (ls[OpFreq] <<< 1) - tx_term - rx_term - off;
    if (hi_tx2_q && hi_rx2_q) begin
      base_d = base_hh_q;
    end else if (hi_tx2_q || hi_rx2_q) begin
      base_d = base_h_q;
    end else begin
      base_d = base_ll_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      sum_q   <= sum_d;
      base3_q <= base_d;
      zero3_q <= zero2_q;
    end
  end

  // Stage 4: scale to dB.
  logic signed [ProdW-1:0] prod_q;
  logic [13:0]             base4_q;
  logic                    zero4_q;

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      prod_q  <= sum_q * DB_SCALE;
      base4_q <= base3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: round half up, add the base loss and saturate; a zero operand gives zero.
  logic signed [ProdW-1:0] rnd;
  logic signed [17:0]      q_db;
  logic signed [19:0]      total;
  logic signed [15:0]      loss_d;
  logic [1:0]              status_d;

  always_comb begin
    rnd   = prod_q + RND_HALF;
    q_db  = rnd[ProdW-1:30];
    total = $signed({{2{q_db[17]}}, q_db}) + $signed({6'd0, base4_q});
    if (zero4_q) begin
      loss_d   = 16'sd0;
      status_d = ST_ZERO;
    end else if (total > 20'sd32767) begin
      loss_d   = 16'sh7FFF;
      status_d = ST_SAT;
    end else if (total < -20'sd32768) begin
      loss_d   = 16'sh8000;
      status_d = ST_SAT;
    end else begin
      loss_d   = total[15:0];
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      loss_db_o <= loss_d;
      status_o  <= status_d;
    end
  end

  assign out_valid_o = v5_q;

  // Checks on the pipeline and the result coding.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
    else $error("input stalled while a stage is empty");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_ZERO) |-> loss_db_o == 16'sd0)
    else $error("zero operand result carries a nonzero loss");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SAT) |->
      (loss_db_o == 16'sh7FFF || loss_db_o == 16'sh8000))
    else $error("saturated result not at a limit");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_ZERO || status_o == ST_SAT))
    else $error("undefined status code");

endmodule

`default_nettype wire
